/* rtl/alm_pkg.sv */
// ----------------------------------------------------------------------------
// alm_pkg
// Types, codes and defaults shared by the multi-slot alarm table modules.
// ----------------------------------------------------------------------------
package alm_pkg;

    localparam int MAX_ALARMS_DEF = 3;
    localparam int MAX_ALARMS_LIM = 16;

    // request codes
    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    // status codes
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_REPLACED = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_BAD_SLOT = 2'd3;

    typedef struct packed {
        logic [1:0] req_type;
        logic [4:0] time_hour;
        logic [5:0] time_minute;
        logic [7:0] repeat_word;
        logic [3:0] slot;
    } alm_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] fired_mask;
        logic        minute_changed;
        logic        clear_steps;
        logic [4:0]  entry_count;
    } alm_out_t;

    typedef enum logic {
        CTRL_IDLE,
        CTRL_EXEC
    } alm_state_t;

    typedef struct packed {
        logic load;  // capture the incoming transaction
        logic exec;  // update the table and load the result register
    } alm_cmd_t;

endpackage

/* rtl/multi_slot_alarm_table_top.sv */
// ----------------------------------------------------------------------------
// multi_slot_alarm_table_top
// Alarm table with add, delete, clear and minute-tick matching.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carries one request transaction (add, delete slot,
//   time tick, clear). Every request yields exactly one result transaction on
//   m_valid/m_ready/m_data with a status, the mask of fired slots, the
//   minute-change and step-clear flags, and the entry count afterwards.
//   The request is captured at the accepting edge and the whole table is
//   compared and updated in parallel in the execute state once the result
//   register is free; m_valid rises when that update is registered. The
//   controller's capture/execute sequence takes one request at a time, and a
//   new request is not accepted until the previous one has been executed.
//   A new request is accepted while the previous result still waits; its
//   update is held until the result register has been taken, so a stalled
//   receiver holds m_data steady and back-pressures s_ready.
//   Reset (aresetn low, synchronous) empties the table and sets the last
//   minute seen to zero; entry contents are not cleared and need no sweep.
// ----------------------------------------------------------------------------
module multi_slot_alarm_table_top import alm_pkg::*; #(
    parameter int MAX_ALARMS = MAX_ALARMS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  alm_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output alm_out_t m_data
);

    alm_cmd_t cmd;

    alm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    alm_datapath #(
        .MAX_ALARMS (MAX_ALARMS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_data  (s_data),
        .out_data (m_data)
    );

endmodule

/* rtl/alm_datapath.sv */
// ----------------------------------------------------------------------------
// alm_datapath
// Request register, alarm table storage, entry count, last minute and the
// result register. Updates happen on exec; the request register loads on load.
// ----------------------------------------------------------------------------
module alm_datapath import alm_pkg::*; #(
    parameter int MAX_ALARMS = MAX_ALARMS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  alm_cmd_t cmd,
    input  alm_in_t  in_data,
    output alm_out_t out_data
);

    alm_in_t  req_reg;
    alm_out_t out_reg;
    alm_out_t out_next;

    logic [4:0] hour_reg   [MAX_ALARMS];
    logic [5:0] minute_reg [MAX_ALARMS];
    logic [7:0] repeat_reg [MAX_ALARMS];
    logic       valid_reg  [MAX_ALARMS];
    logic [4:0] hour_next   [MAX_ALARMS];
    logic [5:0] minute_next [MAX_ALARMS];
    logic [7:0] repeat_next [MAX_ALARMS];
    logic       valid_next  [MAX_ALARMS];

    logic [4:0] count_reg, count_next;
    logic [5:0] last_minute_reg, last_minute_next;

    logic [MAX_ALARMS-1:0] in_use;
    logic [MAX_ALARMS-1:0] addr_hit;
    logic [MAX_ALARMS-1:0] first_hit;
    logic                  any_hit;
    logic [4:0]            slot_ext;

    localparam logic [4:0] MAX_COUNT = 5'(MAX_ALARMS);

    // per-entry compare against the request's time
    always_comb begin
        any_hit = 1'b0;
        for (int i = 0; i < MAX_ALARMS; i++) begin
            in_use[i]    = 5'(i) < count_reg;
            addr_hit[i]  = in_use[i] && (hour_reg[i] == req_reg.time_hour)
                           && (minute_reg[i] == req_reg.time_minute);
            first_hit[i] = addr_hit[i] && !any_hit;
            any_hit      = any_hit || addr_hit[i];
        end
    end

    assign slot_ext = {1'b0, req_reg.slot};

    always_comb begin
        for (int i = 0; i < MAX_ALARMS; i++) begin
            hour_next[i]   = hour_reg[i];
            minute_next[i] = minute_reg[i];
            repeat_next[i] = repeat_reg[i];
            valid_next[i]  = valid_reg[i];
        end
        count_next       = count_reg;
        last_minute_next = last_minute_reg;
        out_next         = '0;

        unique case (req_reg.req_type)
            REQ_ADD: begin
                if (any_hit) begin
                    out_next.status = ST_REPLACED;
                    for (int i = 0; i < MAX_ALARMS; i++) begin
                        if (first_hit[i]) begin
                            repeat_next[i] = req_reg.repeat_word;
                            valid_next[i]  = 1'b1;
                        end
                    end
                end else if (count_reg >= MAX_COUNT) begin
                    out_next.status = ST_FULL;
                end else begin
                    for (int i = 0; i < MAX_ALARMS; i++) begin
                        if (5'(i) == count_reg) begin
                            hour_next[i]   = req_reg.time_hour;
                            minute_next[i] = req_reg.time_minute;
                            repeat_next[i] = req_reg.repeat_word;
                            valid_next[i]  = 1'b1;
                        end
                    end
                    count_next = count_reg + 5'd1;
                end
            end
            REQ_DELETE: begin
                if (slot_ext >= count_reg) begin
                    out_next.status = ST_BAD_SLOT;
                end else begin
                    // close the gap: every entry from the slot up, save the last, takes its successor
                    for (int i = 0; i < MAX_ALARMS - 1; i++) begin
                        if (5'(i) >= slot_ext) begin
                            hour_next[i]   = hour_reg[i+1];
                            minute_next[i] = minute_reg[i+1];
                            repeat_next[i] = repeat_reg[i+1];
                            valid_next[i]  = valid_reg[i+1];
                        end
                    end
                    count_next = count_reg - 5'd1;
                end
            end
            REQ_TICK: begin
                if (req_reg.time_minute != last_minute_reg) begin
                    last_minute_next        = req_reg.time_minute;
                    out_next.minute_changed = 1'b1;
                    out_next.clear_steps    = (req_reg.time_hour == 5'd0)
                                              && (req_reg.time_minute == 6'd0);
                    for (int i = 0; i < MAX_ALARMS; i++) begin
                        if (addr_hit[i] && valid_reg[i]) begin
                            out_next.fired_mask[i] = 1'b1;
                            if (repeat_reg[i] == 8'd0) begin
                                valid_next[i] = 1'b0;
                            end
                        end
                    end
                end
            end
            REQ_CLEAR: begin
                count_next = 5'd0;
            end
            default: begin
                count_next = count_reg;
            end
        endcase
        out_next.entry_count = count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg       <= 5'd0;
            last_minute_reg <= 6'd0;
        end else if (cmd.exec) begin
            count_reg       <= count_next;
            last_minute_reg <= last_minute_next;
        end
    end

    // table contents and payload carry no reset
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= in_data;
        end
        if (cmd.exec) begin
            out_reg <= out_next;
            for (int i = 0; i < MAX_ALARMS; i++) begin
                hour_reg[i]   <= hour_next[i];
                minute_reg[i] <= minute_next[i];
                repeat_reg[i] <= repeat_next[i];
                valid_reg[i]  <= valid_next[i];
            end
        end
    end

    assign out_data = out_reg;

endmodule

/* rtl/alm_ctrl.sv */
// ----------------------------------------------------------------------------
// alm_ctrl
// Handshake controller: takes one transaction, then runs the table update as
// soon as the result register is free, and tracks the result valid flag.
// ----------------------------------------------------------------------------
module alm_ctrl import alm_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output alm_cmd_t cmd
);

    alm_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            CTRL_IDLE: begin
                if (s_valid) begin
                    state_next = CTRL_EXEC;
                end
            end
            CTRL_EXEC: begin
                if (out_free) begin
                    state_next = CTRL_IDLE;
                end
            end
            default: begin
                state_next = CTRL_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            CTRL_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            CTRL_EXEC: begin
                cmd.exec = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // hold the result until taken, refill when exec lands
    always_comb begin
        if (cmd.exec) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CTRL_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

/* rtl/alm_checker.sv */
// ----------------------------------------------------------------------------
// alm_checker
// Port-level checks for the alarm table, bound to the top level.
// ----------------------------------------------------------------------------
module alm_checker import alm_pkg::*; #(
    parameter int MAX_ALARMS = MAX_ALARMS_DEF
) (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input alm_out_t m_data
);

    // one transaction in flight: no accept on the cycle right after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted back to back");

    // fire and step-clear flags only come with a new minute
    a_flags_need_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.minute_changed) |->
            (m_data.fired_mask == 16'd0 && !m_data.clear_steps))
        else $error("fire flags without a minute change");

    // count stays within the table
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.entry_count <= 5'(MAX_ALARMS)))
        else $error("entry count beyond table size");

    // a tick only fires slots that are in use
    a_fired_in_use: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.fired_mask >> m_data.entry_count) == 16'd0))
        else $error("fired slot beyond entry count");

    // stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed while stalled");

endmodule

bind multi_slot_alarm_table_top alm_checker #(
    .MAX_ALARMS (MAX_ALARMS)
) u_alm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

/* tb/tb_multi_slot_alarm_table_top.sv */
// ----------------------------------------------------------------------------
// tb_multi_slot_alarm_table_top
// Self-checking bench for the alarm table. A short directed table covers the
// edge cases: an empty table, a full table, replacing an entry, one-shot
// alarms, the midnight tick, ticks within the same minute and deletes out of
// range. Random traffic follows, drawn from a small pool of alarm times so
// that ticks match table entries. A behavioral model of the table predicts
// each unpinned response; every response is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_multi_slot_alarm_table_top;
    timeunit 1ns;
    timeprecision 1ps;

    import alm_pkg::*;

    localparam int SLOTS        = MAX_ALARMS_DEF;
    localparam int RANDOM_ITEMS = 1150;
    localparam int TIME_POOL    = 5;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        alm_in_t  req;
        bit       pinned;
        alm_out_t result;
    } directed_row_t;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    alm_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    alm_out_t m_data;

    // expected response typed into the directed table, travels with s_data
    bit       pin_valid = 1'b0;
    alm_out_t pinned_result = '0;

    // behavioral copy of the alarm table
    logic [4:0] alarm_hour [SLOTS] = '{default: '0};
    logic [5:0] alarm_minute [SLOTS] = '{default: '0};
    logic [7:0] alarm_repeat [SLOTS] = '{default: '0};
    logic       alarm_armed [SLOTS] = '{default: 1'b0};
    int         alarm_count = 0;
    logic [5:0] prev_minute = '0;

    alm_out_t      expected_results[$];
    directed_row_t directed_rows[$];
    int            error_count = 0;
    int            sent_count = 0;
    int            send_idle_pct = 17;
    int            recv_idle_pct = 69;
    int            total_items;

    multi_slot_alarm_table_top #(
        .MAX_ALARMS(SLOTS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    function automatic alm_out_t apply_alarm_request(alm_in_t req);
        alm_out_t res;
        int       idx;
        res = '0;
        case (req.req_type)
            REQ_ADD: begin
                idx = alarm_count;
                // lowest matching entry wins
                for (int i = alarm_count - 1; i >= 0; i--) begin
                    if (alarm_hour[i] == req.time_hour && alarm_minute[i] == req.time_minute)
                        idx = i;
                end
                if (idx < alarm_count)
                    res.status = ST_REPLACED;
                else if (alarm_count >= SLOTS)
                    res.status = ST_FULL;
                if (res.status != ST_FULL) begin
                    alarm_hour[idx]   = req.time_hour;
                    alarm_minute[idx] = req.time_minute;
                    alarm_repeat[idx] = req.repeat_word;
                    alarm_armed[idx]  = 1'b1;
                    if (idx == alarm_count)
                        alarm_count++;
                end
            end
            REQ_DELETE: begin
                if (int'(req.slot) >= alarm_count) begin
                    res.status = ST_BAD_SLOT;
                end else begin
                    // close the gap
                    for (int i = req.slot; i + 1 < alarm_count; i++) begin
                        alarm_hour[i]   = alarm_hour[i + 1];
                        alarm_minute[i] = alarm_minute[i + 1];
                        alarm_repeat[i] = alarm_repeat[i + 1];
                        alarm_armed[i]  = alarm_armed[i + 1];
                    end
                    alarm_count--;
                end
            end
            REQ_TICK: begin
                if (req.time_minute != prev_minute) begin
                    prev_minute = req.time_minute;
                    res.minute_changed = 1'b1;
                    res.clear_steps = (req.time_hour == 0 && req.time_minute == 0);
                    for (int i = 0; i < alarm_count; i++) begin
                        if (alarm_armed[i] && alarm_hour[i] == req.time_hour
                                && alarm_minute[i] == req.time_minute) begin
                            res.fired_mask[i] = 1'b1;
                            if (alarm_repeat[i] == 0)
                                alarm_armed[i] = 1'b0;
                        end
                    end
                end
            end
            default: begin
                alarm_count = 0;
            end
        endcase
        res.entry_count = 5'(alarm_count);
        return res;
    endfunction

    function automatic directed_row_t drow(logic [1:0] op, int hr, int mn, int rep, int sl,
                                           bit pin, logic [1:0] st, int cnt);
        directed_row_t r;
        r.req = '{req_type: op, time_hour: 5'(hr), time_minute: 6'(mn),
                  repeat_word: 8'(rep), slot: 4'(sl)};
        r.pinned = pin;
        r.result = '{status: st, fired_mask: 16'd0, minute_changed: 1'b0,
                     clear_steps: 1'b0, entry_count: 5'(cnt)};
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        error_count++;
    endtask

    // entered and left at a falling edge
    task automatic send_request(alm_in_t req, bit pin, alm_out_t pin_res);
        case ((sent_count * 3) / total_items)
            0: begin send_idle_pct = 17; recv_idle_pct = 69; end
            1: begin send_idle_pct = 69; recv_idle_pct = 17; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
        endcase
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= req;
        pin_valid <= pin;
        pinned_result <= pin_res;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sent_count++;
        @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin : response_check
        alm_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                want = apply_alarm_request(s_data);
                expected_results.push_back(pin_valid ? pinned_result : want);
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected response", int'(m_data), 0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.status != want.status)
                        report_mismatch("status", int'(m_data.status), int'(want.status));
                    if (m_data.fired_mask != want.fired_mask)
                        report_mismatch("fired_mask", int'(m_data.fired_mask),
                                        int'(want.fired_mask));
                    if (m_data.minute_changed != want.minute_changed)
                        report_mismatch("minute_changed", int'(m_data.minute_changed),
                                        int'(want.minute_changed));
                    if (m_data.clear_steps != want.clear_steps)
                        report_mismatch("clear_steps", int'(m_data.clear_steps),
                                        int'(want.clear_steps));
                    if (m_data.entry_count != want.entry_count)
                        report_mismatch("entry_count", int'(m_data.entry_count),
                                        int'(want.entry_count));
                end
            end
        end
    end

    initial begin : watchdog
        for (int cycles = 0; cycles < CYCLE_LIMIT; cycles++)
            @(posedge aclk);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [4:0] pool_hour [TIME_POOL];
        logic [5:0] pool_minute [TIME_POOL];
        alm_in_t    req;
        int         pick;
        int         kind;

        directed_rows.push_back(drow(REQ_DELETE, 0, 0, 0, 0, 1, ST_BAD_SLOT, 0));
        directed_rows.push_back(drow(REQ_TICK, 0, 0, 0, 0, 1, ST_DONE, 0));
        directed_rows.push_back(drow(REQ_ADD, 23, 59, 0, 0, 1, ST_DONE, 1));
        directed_rows.push_back(drow(REQ_ADD, 0, 0, 255, 15, 1, ST_DONE, 2));
        directed_rows.push_back(drow(REQ_ADD, 31, 63, 8'h80, 10, 1, ST_DONE, 3));
        directed_rows.push_back(drow(REQ_ADD, 5, 5, 1, 0, 1, ST_FULL, 3));
        directed_rows.push_back(drow(REQ_ADD, 23, 59, 7, 0, 1, ST_REPLACED, 3));
        directed_rows.push_back(drow(REQ_ADD, 23, 59, 0, 0, 1, ST_REPLACED, 3));
        directed_rows.push_back(drow(REQ_TICK, 23, 59, 8'hAA, 5, 0, ST_DONE, 0));
        directed_rows.push_back(drow(REQ_TICK, 23, 59, 0, 0, 0, ST_DONE, 0));
        directed_rows.push_back(drow(REQ_TICK, 31, 63, 8'h55, 10, 0, ST_DONE, 0));
        directed_rows.push_back(drow(REQ_TICK, 0, 0, 0, 0, 0, ST_DONE, 0));
        directed_rows.push_back(drow(REQ_TICK, 23, 59, 0, 0, 0, ST_DONE, 0));
        directed_rows.push_back(drow(REQ_DELETE, 31, 63, 255, 15, 1, ST_BAD_SLOT, 3));
        directed_rows.push_back(drow(REQ_DELETE, 0, 0, 0, 3, 1, ST_BAD_SLOT, 3));
        directed_rows.push_back(drow(REQ_DELETE, 0, 0, 0, 0, 0, ST_DONE, 0));
        directed_rows.push_back(drow(REQ_ADD, 23, 59, 0, 0, 0, ST_DONE, 0));
        directed_rows.push_back(drow(REQ_DELETE, 0, 0, 0, 2, 0, ST_DONE, 0));
        directed_rows.push_back(drow(REQ_DELETE, 0, 0, 0, 0, 0, ST_DONE, 0));
        directed_rows.push_back(drow(REQ_CLEAR, 31, 63, 255, 15, 1, ST_DONE, 0));
        directed_rows.push_back(drow(REQ_DELETE, 0, 0, 0, 0, 1, ST_BAD_SLOT, 0));
        directed_rows.push_back(drow(REQ_TICK, 0, 1, 255, 15, 0, ST_DONE, 0));
        directed_rows.push_back(drow(REQ_ADD, 12, 30, 0, 15, 0, ST_DONE, 0));
        directed_rows.push_back(drow(REQ_TICK, 12, 30, 0, 0, 0, ST_DONE, 0));
        directed_rows.push_back(drow(REQ_ADD, 12, 30, 3, 0, 0, ST_DONE, 0));
        total_items = directed_rows.size() + RANDOM_ITEMS;

        for (int i = 0; i < TIME_POOL; i++) begin
            pool_hour[i] = 5'($urandom_range(0, 31));
            pool_minute[i] = 6'($urandom_range(0, 63));
        end

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].pinned, directed_rows[i].result);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // unused fields carry noise
            req = alm_in_t'($urandom);
            // occasionally move a pooled alarm time
            if ($urandom_range(0, 99) < 3) begin
                pick = $urandom_range(0, TIME_POOL - 1);
                pool_hour[pick] = 5'($urandom_range(0, 31));
                pool_minute[pick] = 6'($urandom_range(0, 63));
            end
            if ($urandom_range(0, 99) < 75) begin
                pick = $urandom_range(0, TIME_POOL - 1);
                req.time_hour = pool_hour[pick];
                req.time_minute = pool_minute[pick];
            end
            if ($urandom_range(0, 99) < 40)
                req.repeat_word = '0;
            kind = $urandom_range(0, 99);
            if (kind < 36) begin
                req.req_type = REQ_ADD;
            end else if (kind < 74) begin
                req.req_type = REQ_TICK;
            end else if (kind < 95) begin
                req.req_type = REQ_DELETE;
                if ($urandom_range(0, 99) < 80)
                    req.slot = 4'($urandom_range(0, SLOTS));
            end else begin
                req.req_type = REQ_CLEAR;
            end
            send_request(req, 1'b0, '0);
        end
        s_valid <= 1'b0;

        while (expected_results.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);

        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/alm_pkg.sv
rtl/alm_datapath.sv
rtl/alm_ctrl.sv
rtl/multi_slot_alarm_table_top.sv
rtl/alm_checker.sv
tb/tb_multi_slot_alarm_table_top.sv
